>>> src/vtws_pkg.sv
// vtws_pkg: shared types, codes and defaults for the voice table with stealing
// no dependencies; imported by voice_table_with_stealing and vtws_checker
package vtws_pkg;

   // defaults for the top level parameter and the csr reset
   localparam int          SLOTS_DEFAULT    = 16;
   localparam logic [4:0]  MAX_VOICES_RESET = 5'd8;

   // fixed field widths
   localparam int CMD_W    = 2;
   localparam int ID_W     = 8;
   localparam int GAIN_W   = 16;
   localparam int MASK_W   = 16;
   localparam int IDX_W    = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int MAXV_W   = 5;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // command codes
   localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RETIRE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   // csr register index (byte address bit 2 upwards)
   localparam logic REG_MAX_VOICES = 1'b0;

   // one table entry as stored in the ram
   typedef struct packed {
      logic [ID_W-1:0]   sound_id;
      logic              priority_bit;
      logic              dropped;
      logic [GAIN_W-1:0] gain;
   } entry_type;

endpackage

>>> src/vtws_ram.sv
// vtws_ram: generic single write port, single read port ram with registered read
// no dependencies; used by voice_table_with_stealing for the voice table
module vtws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/voice_table_with_stealing.sv
// voice_table_with_stealing: top level of the voice allocation table
// depends on vtws_pkg and vtws_ram
//
// Age-ordered voice table held in one ram, position 0 oldest. One command word is
// taken at a time and gives one response word, which is loaded into the output
// register at the same edge that the sequencer returns to idle for the next command.
// A start that needs no steal, a refused start, a read out of range, a retire of an
// empty table and an unknown command go straight to the response; a read in range
// first waits for the registered ram read. A start that steals scans the ram one
// entry a cycle for the oldest stealable voice, and the marked entry is then written
// back. A retire compacts the table in place, with one read per entry and one
// compacting write per kept entry, through the
// single ram port pair. A new command is taken while the previous response still
// waits in the output register; a finished word that finds the output register
// still full holds the sequencer until the response channel takes the older word.
// No clearing pass after reset is needed.
module voice_table_with_stealing #(
   parameter int SLOTS = vtws_pkg::SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // apb-style csr port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [vtws_pkg::CSR_AW-1:0]     paddr,
   input  logic [vtws_pkg::CSR_DW-1:0]     pwdata,
   output logic [vtws_pkg::CSR_DW-1:0]     prdata,
   output logic                            pready,
   // command channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [vtws_pkg::CMD_W-1:0]      req_command,
   input  logic [vtws_pkg::ID_W-1:0]       req_sound_id,
   input  logic                            req_priority_req,
   input  logic [vtws_pkg::GAIN_W-1:0]     req_loudness,
   input  logic [vtws_pkg::MASK_W-1:0]     req_ended_mask,
   input  logic [vtws_pkg::IDX_W-1:0]      req_read_index,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [vtws_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_drop_valid,
   output logic [vtws_pkg::ID_W-1:0]       rsp_drop_sound_id,
   output logic [vtws_pkg::COUNT_W-1:0]    rsp_voice_count,
   output logic [vtws_pkg::ID_W-1:0]       rsp_entry_sound_id,
   output logic                            rsp_entry_priority,
   output logic                            rsp_entry_dropped,
   output logic [vtws_pkg::GAIN_W-1:0]     rsp_entry_loudness
);
   import vtws_pkg::*;

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int EW = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_RETIRE,
      ST_READ_WAIT,
      ST_RESP
   } state_type;

   state_type           state_ff;
   logic [MAXV_W-1:0]   max_voices_ff;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       last_ff;
   logic [CW-1:0]       ptr_ff;
   logic [CW-1:0]       wptr_ff;
   logic [MASK_W-1:0]   mask_ff;
   entry_type           new_ff;
   entry_type           cand_ff;
   logic [AW-1:0]       cand_idx_ff;
   logic                free_found_ff;
   logic                unm_found_ff;

   logic [STATUS_W-1:0] res_status_ff;
   logic [STATUS_W-1:0] res_status_in;
   logic                res_drop_valid_ff;
   logic [ID_W-1:0]     res_drop_id_ff;
   entry_type           res_entry_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_drop_valid_ff;
   logic [ID_W-1:0]     rsp_drop_id_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   entry_type           rsp_entry_ff;
   logic                rsp_load;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [EW-1:0]       ram_wdata;
   logic [AW-1:0]       ram_raddr;
   logic [EW-1:0]       ram_rdata;
   entry_type           rd_entry;

   logic                accept;
   logic                table_full;
   logic                need_steal;
   logic                read_range;
   logic [CW+3:0]       idx_wide;
   logic [AW-1:0]       idx_addr;
   logic [CW-1:0]       ptr_next;
   logic                scan_last;
   logic                rd_free;
   logic [CW+4:0]       ptr_wide;
   logic                rd_ended;
   logic                rd_keep;
   logic                use_cand;
   logic [AW-1:0]       mark_addr;
   entry_type           mark_entry;
   logic [CW+4:0]       count_wide;

   // csr port: one register, decoded on the word index
   always_ff @(posedge clock) begin
      if (reset) begin
         max_voices_ff <= MAX_VOICES_RESET;
      end else if (psel && penable && pwrite && pready
                   && (paddr[2] == REG_MAX_VOICES)) begin
         max_voices_ff <= pwdata[MAXV_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_MAX_VOICES) ? CSR_DW'(max_voices_ff) : '0;

   // voice table ram
   vtws_ram #(
      .WIDTH (EW),
      .DEPTH (SLOTS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_entry = entry_type'(ram_rdata);

   // command decode helpers
   assign accept     = req_valid && req_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign table_full = (count_ff == CW'(SLOTS));
   assign need_steal = ((CW+5)'(count_ff) + (CW+5)'(1)) > (CW+5)'(max_voices_ff);
   assign idx_wide   = (CW+4)'(req_read_index);
   assign read_range = idx_wide >= (CW+4)'(count_ff);
   assign idx_addr   = idx_wide[AW-1:0];

   // status of the accepted command as known at accept time
   assign res_status_in = ((req_command == CMD_START) && table_full) ? STATUS_FULL :
                          ((req_command == CMD_READ) && read_range)  ? STATUS_RANGE :
                                                                       STATUS_OK;

   // scan and compaction helpers for the entry on the read port
   assign ptr_next  = ptr_ff + CW'(1);
   assign scan_last = (ptr_next == last_ff);
   assign rd_free   = !rd_entry.dropped && !rd_entry.priority_bit;
   assign ptr_wide  = (CW+5)'(ptr_ff);
   assign rd_ended  = (ptr_wide < (CW+5)'(MASK_W)) && mask_ff[ptr_wide[3:0]];
   assign rd_keep   = !rd_entry.dropped && !rd_ended;

   // steal choice: oldest free, else the new voice if not priority,
   // else oldest unmarked, else the new voice
   assign use_cand   = free_found_ff || (new_ff.priority_bit && unm_found_ff);
   assign mark_addr  = use_cand ? cand_idx_ff : last_ff[AW-1:0];
   assign mark_entry = use_cand ? cand_ff : new_ff;

   // finished word moves into the output register once that is free
   assign rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   // ram port control
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_raddr = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_command == CMD_START) && !table_full) begin
               ram_we    = 1'b1;
               ram_waddr = count_ff[AW-1:0];
               ram_wdata = {req_sound_id, req_priority_req, 1'b0, req_loudness};
            end
            if (req_command == CMD_READ) begin
               ram_raddr = idx_addr;
            end
         end
         ST_SCAN: begin
            ram_raddr = ptr_next[AW-1:0];
         end
         ST_RETIRE: begin
            ram_raddr = ptr_next[AW-1:0];
            if (rd_keep) begin
               ram_we    = 1'b1;
               ram_waddr = wptr_ff[AW-1:0];
               ram_wdata = rd_entry;
            end
         end
         ST_MARK: begin
            ram_we    = 1'b1;
            ram_waddr = mark_addr;
            ram_wdata = {mark_entry.sound_id, mark_entry.priority_bit, 1'b1,
                         mark_entry.gain};
         end
         default: begin
            ram_raddr = '0;
         end
      endcase
   end

   // sequencer with result and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         unm_found_ff  <= 1'b0;
      end else begin
         // output register valid: set on load, cleared once taken
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  res_status_ff     <= res_status_in;
                  res_drop_valid_ff <= 1'b0;
                  res_drop_id_ff    <= '0;
                  res_entry_ff      <= '0;
                  last_ff           <= count_ff;
                  ptr_ff            <= '0;
                  wptr_ff           <= '0;
                  free_found_ff     <= 1'b0;
                  unm_found_ff      <= 1'b0;
                  mask_ff           <= req_ended_mask;
                  new_ff            <= {req_sound_id, req_priority_req, 1'b0, req_loudness};
                  case (req_command)
                     CMD_START: begin
                        if (table_full) begin
                           state_ff <= ST_RESP;
                        end else begin
                           count_ff <= count_ff + CW'(1);
                           if (!need_steal) begin
                              state_ff <= ST_RESP;
                           end else if (count_ff == '0) begin
                              state_ff <= ST_MARK;
                           end else begin
                              state_ff <= ST_SCAN;
                           end
                        end
                     end
                     CMD_RETIRE: begin
                        state_ff <= (count_ff == '0) ? ST_RESP : ST_RETIRE;
                     end
                     CMD_READ: begin
                        if (read_range) begin
                           state_ff <= ST_RESP;
                        end else begin
                           state_ff <= ST_READ_WAIT;
                        end
                     end
                     default: begin
                        state_ff <= ST_RESP;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               ptr_ff <= ptr_next;
               if (rd_free) begin
                  cand_ff       <= rd_entry;
                  cand_idx_ff   <= ptr_ff[AW-1:0];
                  free_found_ff <= 1'b1;
                  state_ff      <= ST_MARK;
               end else begin
                  if (!rd_entry.dropped && !unm_found_ff) begin
                     cand_ff      <= rd_entry;
                     cand_idx_ff  <= ptr_ff[AW-1:0];
                     unm_found_ff <= 1'b1;
                  end
                  if (scan_last) begin
                     state_ff <= ST_MARK;
                  end
               end
            end
            ST_MARK: begin
               res_drop_valid_ff <= 1'b1;
               res_drop_id_ff    <= mark_entry.sound_id;
               state_ff          <= ST_RESP;
            end
            ST_RETIRE: begin
               ptr_ff <= ptr_next;
               if (rd_keep) begin
                  wptr_ff <= wptr_ff + CW'(1);
               end
               if (scan_last) begin
                  count_ff <= wptr_ff + CW'(rd_keep);
                  state_ff <= ST_RESP;
               end
            end
            ST_READ_WAIT: begin
               res_entry_ff <= rd_entry;
               state_ff     <= ST_RESP;
            end
            ST_RESP: begin
               if (rsp_load) begin
                  rsp_status_ff     <= res_status_ff;
                  rsp_drop_valid_ff <= res_drop_valid_ff;
                  rsp_drop_id_ff    <= res_drop_id_ff;
                  rsp_count_ff      <= count_wide[COUNT_W-1:0];
                  rsp_entry_ff      <= res_entry_ff;
                  state_ff          <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign count_wide = (CW+5)'(count_ff);

   // response ports
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_drop_valid     = rsp_drop_valid_ff;
   assign rsp_drop_sound_id  = rsp_drop_id_ff;
   assign rsp_voice_count    = rsp_count_ff;
   assign rsp_entry_sound_id = rsp_entry_ff.sound_id;
   assign rsp_entry_priority = rsp_entry_ff.priority_bit;
   assign rsp_entry_dropped  = rsp_entry_ff.dropped;
   assign rsp_entry_loudness = rsp_entry_ff.gain;

endmodule

>>> src/vtws_checker.sv
// vtws_checker: port-level checks on voice_table_with_stealing, bound to the top level
// depends on vtws_pkg and voice_table_with_stealing
module vtws_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            pready,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [vtws_pkg::STATUS_W-1:0]   rsp_status,
   input logic                            rsp_drop_valid,
   input logic [vtws_pkg::COUNT_W-1:0]    rsp_voice_count,
   input logic                            rsp_entry_dropped,
   input logic [vtws_pkg::GAIN_W-1:0]     rsp_entry_loudness
);
   import vtws_pkg::*;

   // a refused start reports no steal and no entry
   a_full_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |->
         !rsp_drop_valid && (rsp_entry_loudness == '0))
      else $error("refused start reported a drop or an entry");

   // a steal only comes with an ok start word, no entry fields
   a_drop_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drop_valid |->
         (rsp_status == STATUS_OK) && !rsp_entry_dropped && (rsp_entry_loudness == '0))
      else $error("drop reported with a bad status or entry fields");

   // one command in flight: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command taken while the previous one is in flight");

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_status) && $stable(rsp_voice_count))
      else $error("response word changed while stalled");

   // the csr port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind voice_table_with_stealing vtws_checker u_vtws_checker (.*);
